FILE: rtl/segment_intersection_macros.svh
// ----------------------------------------------------------------------------
// segment_intersection_macros.svh
// Assertion macros for the segment intersection pipeline.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_MACROS_SVH
`define SEGMENT_INTERSECTION_MACROS_SVH
`ifndef SYNTHESIS
// condition and property checked in the same cycle
`define SEGINT_ASSERT_SAME(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("segment_intersection: same-cycle check failed");
// property checked in the cycle after the condition
`define SEGINT_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("segment_intersection: next-cycle check failed");
`else
`define SEGINT_ASSERT_SAME(label, clk, rst_n, cond, prop)
`define SEGINT_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

FILE: rtl/segint_pkg.sv
// ----------------------------------------------------------------------------
// segint_pkg
// Shared coordinate width and transfer payload types of the segment
// intersection block.
// ----------------------------------------------------------------------------
`default_nettype none

package segint_pkg;

	// coordinate width, signed Q8.8 at the default
	localparam int COORD_WIDTH = 16;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	// one segment pair
	typedef struct packed {
		coord_t seg1_start_x;
		coord_t seg1_start_y;
		coord_t seg1_end_x;
		coord_t seg1_end_y;
		coord_t seg2_start_x;
		coord_t seg2_start_y;
		coord_t seg2_end_x;
		coord_t seg2_end_y;
	} seg_pair_t;

	// one intersection result
	typedef struct packed {
		logic   hit;
		logic   parallel;
		coord_t cross_x;
		coord_t cross_y;
	} isect_t;

endpackage

`default_nettype wire

FILE: rtl/segment_intersection.sv
// ----------------------------------------------------------------------------
// segment_intersection
// Pipelined 2D segment intersection by cross products: hit test on the
// exact rationals t and u, and the crossing point p + r*t with a restoring
// divider that yields one quotient bit per stage.
// ----------------------------------------------------------------------------
//
//  channel | valid        | ready        | payload
//  --------+--------------+--------------+---------------------------
//  in      | seg_valid    | seg_ready    | seg   (segint_pkg::seg_pair_t)
//  out     | isect_valid  | isect_ready  | isect (segint_pkg::isect_t)
//
//  One segment pair enters per cycle while seg_ready is high; the divider
//  resolves one quotient bit per stage for COORD_WIDTH + 1 stages.
//  Reset clears the valid bits only; the data registers carry no reset.
//  Each stage holds when its successor is full and stalled, so bubbles are
//  squeezed out and the input keeps taking transfers while results wait,
//  until every stage is full.
//
`default_nettype none

module segment_intersection (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    seg_valid,
	output logic                   seg_ready,
	input  segint_pkg::seg_pair_t  seg,
	output logic                   isect_valid,
	input  wire                    isect_ready,
	output segint_pkg::isect_t     isect
);

`include "segment_intersection_macros.svh"

	localparam int W    = segint_pkg::COORD_WIDTH;
	localparam int DW   = W + 1;        // coordinate difference
	localparam int CW   = 2 * W + 2;    // cross product, signed
	localparam int MW   = 2 * W + 1;    // denominator magnitude
	localparam int H    = W + 2;        // low split of the numerator
	localparam int HW   = CW - H;       // high split of the numerator
	localparam int LPW  = H + 1 + DW;   // low partial product
	localparam int HPW  = HW + DW;      // high partial product
	localparam int PW   = CW + DW;      // full numerator product, signed
	localparam int RW   = 3 * W + 2;    // divider remainder
	localparam int QW   = W + 1;        // quotient bits resolved
	localparam int NDIV = QW;           // divider stages
	localparam int SW   = W + 3;        // base plus signed quotient

	localparam logic signed [W-1:0]  COORD_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0]  COORD_MIN = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [SW-1:0] SUM_MAX   = {4'b0000, {(W-1){1'b1}}};
	localparam logic signed [SW-1:0] SUM_MIN   = {4'b1111, {(W-1){1'b0}}};

	// per-coordinate data through the divider
	typedef struct packed {
		logic [RW-1:0]          rem;
		logic [QW-1:0]          quo;
		logic                   neg;
		logic                   ovf;
		logic signed [W-1:0]    base;
	} lane_t;

	// data shared by both coordinates
	typedef struct packed {
		logic                   hit;
		logic                   par;
		logic [MW-1:0]          den;
	} side_t;

	function automatic logic signed [DW-1:0] sext(input logic signed [W-1:0] v);
		return {v[W-1], v};
	endfunction

	// stage valids and enables
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_sl;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8, en_sl;
	logic [NDIV-1:0] vld_sd;
	logic [NDIV-1:0] en_sd;

	// stage registers
	logic signed [W-1:0]   base_s1 [2];
	logic signed [DW-1:0]  r_s1 [2];
	logic signed [DW-1:0]  s_s1 [2];
	logic signed [DW-1:0]  d_s1 [2];

	logic signed [W-1:0]   base_s2 [2];
	logic signed [DW-1:0]  r_s2 [2];
	logic signed [CW-1:0]  den_a_s2, den_b_s2, tn_a_s2, tn_b_s2, un_a_s2, un_b_s2;

	logic signed [W-1:0]   base_s3 [2];
	logic signed [DW-1:0]  r_s3 [2];
	logic signed [CW-1:0]  den_s3, tn_s3, un_s3;

	logic signed [W-1:0]   base_s4 [2];
	logic signed [DW-1:0]  r_s4 [2];
	logic [MW-1:0]         den_s4;
	logic signed [CW-1:0]  tn_s4, un_s4;
	logic                  par_s4;

	logic signed [W-1:0]   base_s5 [2];
	logic signed [LPW-1:0] lo_s5 [2];
	logic signed [HPW-1:0] hi_s5 [2];
	logic [MW-1:0]         den_s5;
	logic                  hit_s5, par_s5;

	logic signed [W-1:0]   base_s6 [2];
	logic signed [PW-1:0]  prod_s6 [2];
	logic [MW-1:0]         den_s6;
	logic                  hit_s6, par_s6;

	lane_t                 lane_s7 [2];
	side_t                 side_s7;
	lane_t                 lane_s8 [2];
	side_t                 side_s8;

	lane_t                 lane_sd [NDIV][2];
	side_t                 side_sd [NDIV];

	segint_pkg::isect_t    res_sl;

	// combinational helpers
	logic                  den_neg_c;
	logic signed [CW-1:0]  den_abs_c;
	logic signed [PW-1:0]  prod_abs_c [2];
	lane_t                 lane_s7_c [2];
	lane_t                 lane_s8_c [2];
	logic signed [SW-1:0]  qext_c [2];
	logic signed [SW-1:0]  sum_c [2];
	logic signed [W-1:0]   cross_c [2];
	segint_pkg::isect_t    res_c;

	// ready chain: a stage takes a transfer when empty or when it moves on
	assign en_sl     = ~vld_sl | isect_ready;
	assign en_s8     = ~vld_s8 | en_sd[0];
	assign en_s7     = ~vld_s7 | en_s8;
	assign en_s6     = ~vld_s6 | en_s7;
	assign en_s5     = ~vld_s5 | en_s6;
	assign en_s4     = ~vld_s4 | en_s5;
	assign en_s3     = ~vld_s3 | en_s4;
	assign en_s2     = ~vld_s2 | en_s3;
	assign en_s1     = ~vld_s1 | en_s2;
	assign seg_ready = en_s1;

	// valid bits of the fixed stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_sl <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= seg_valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
			if (en_s6) vld_s6 <= vld_s5;
			if (en_s7) vld_s7 <= vld_s6;
			if (en_s8) vld_s8 <= vld_s7;
			if (en_sl) vld_sl <= vld_sd[NDIV-1];
		end
	end

	// stage 1: direction and offset vectors
	always_ff @(posedge clk) begin
		if (en_s1) begin
			base_s1[0] <= seg.seg1_start_x;
			base_s1[1] <= seg.seg1_start_y;
			r_s1[0]    <= sext(seg.seg1_end_x) - sext(seg.seg1_start_x);
			r_s1[1]    <= sext(seg.seg1_end_y) - sext(seg.seg1_start_y);
			s_s1[0]    <= sext(seg.seg2_end_x) - sext(seg.seg2_start_x);
			s_s1[1]    <= sext(seg.seg2_end_y) - sext(seg.seg2_start_y);
			d_s1[0]    <= sext(seg.seg2_start_x) - sext(seg.seg1_start_x);
			d_s1[1]    <= sext(seg.seg2_start_y) - sext(seg.seg1_start_y);
		end
	end

	// stage 2: the six cross product terms
	always_ff @(posedge clk) begin
		if (en_s2) begin
			base_s2  <= base_s1;
			r_s2     <= r_s1;
			den_a_s2 <= r_s1[0] * s_s1[1];
			den_b_s2 <= r_s1[1] * s_s1[0];
			tn_a_s2  <= d_s1[0] * s_s1[1];
			tn_b_s2  <= d_s1[1] * s_s1[0];
			un_a_s2  <= d_s1[0] * r_s1[1];
			un_b_s2  <= d_s1[1] * r_s1[0];
		end
	end

	// stage 3: denominator and numerators
	always_ff @(posedge clk) begin
		if (en_s3) begin
			base_s3 <= base_s2;
			r_s3    <= r_s2;
			den_s3  <= den_a_s2 - den_b_s2;
			tn_s3   <= tn_a_s2 - tn_b_s2;
			un_s3   <= un_a_s2 - un_b_s2;
		end
	end

	// stage 4: make the denominator positive
	always_comb begin
		den_neg_c = den_s3[CW-1];
		den_abs_c = den_neg_c ? -den_s3 : den_s3;
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			base_s4 <= base_s3;
			r_s4    <= r_s3;
			den_s4  <= den_abs_c[MW-1:0];
			tn_s4   <= den_neg_c ? -tn_s3 : tn_s3;
			un_s4   <= den_neg_c ? -un_s3 : un_s3;
			par_s4  <= (den_s3 == '0);
		end
	end

	// stage 5: range test and split partial products r * tn
	always_ff @(posedge clk) begin
		if (en_s5) begin
			base_s5 <= base_s4;
			den_s5  <= den_s4;
			par_s5  <= par_s4;
			hit_s5  <= !par_s4 && !tn_s4[CW-1] && !un_s4[CW-1]
				&& (tn_s4[MW-1:0] <= den_s4) && (un_s4[MW-1:0] <= den_s4);
			for (int l = 0; l < 2; l++) begin
				lo_s5[l] <= $signed({1'b0, tn_s4[H-1:0]}) * r_s4[l];
				hi_s5[l] <= $signed(tn_s4[CW-1:H]) * r_s4[l];
			end
		end
	end

	// stage 6: join the partial products
	always_ff @(posedge clk) begin
		if (en_s6) begin
			base_s6 <= base_s5;
			den_s6  <= den_s5;
			hit_s6  <= hit_s5;
			par_s6  <= par_s5;
			for (int l = 0; l < 2; l++) begin
				prod_s6[l] <= (PW'(hi_s5[l]) <<< H) + PW'(lo_s5[l]);
			end
		end
	end

	// stage 7: sign and magnitude of the dividend
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			prod_abs_c[l]     = prod_s6[l][PW-1] ? -prod_s6[l] : prod_s6[l];
			lane_s7_c[l].rem  = prod_abs_c[l][RW-1:0];
			lane_s7_c[l].quo  = '0;
			lane_s7_c[l].neg  = prod_s6[l][PW-1];
			lane_s7_c[l].ovf  = 1'b0;
			lane_s7_c[l].base = base_s6[l];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s7) begin
			lane_s7     <= lane_s7_c;
			side_s7.hit <= hit_s6;
			side_s7.par <= par_s6;
			side_s7.den <= den_s6;
		end
	end

	// stage 8: quotient too large for the coordinate range
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			lane_s8_c[l]     = lane_s7[l];
			lane_s8_c[l].ovf = lane_s7[l].rem >= (RW'(side_s7.den) << QW);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s8) begin
			lane_s8 <= lane_s8_c;
			side_s8 <= side_s7;
		end
	end

	// restoring divider, one quotient bit per stage
	for (genvar j = 0; j < NDIV; j++) begin : g_div
		localparam int BIT = QW - 1 - j;

		lane_t         lane_in [2];
		lane_t         lane_nx [2];
		side_t         side_in;
		logic          vld_in;
		logic [RW-1:0] dsh;
		logic          ge [2];

		if (j == 0) begin : g_first
			assign lane_in = lane_s8;
			assign side_in = side_s8;
			assign vld_in  = vld_s8;
		end else begin : g_next
			assign lane_in = lane_sd[j-1];
			assign side_in = side_sd[j-1];
			assign vld_in  = vld_sd[j-1];
		end

		if (j == NDIV - 1) begin : g_en_last
			assign en_sd[j] = ~vld_sd[j] | en_sl;
		end else begin : g_en_mid
			assign en_sd[j] = ~vld_sd[j] | en_sd[j+1];
		end

		assign dsh = RW'(side_in.den) << BIT;

		// trial subtract and next quotient bit
		always_comb begin
			for (int l = 0; l < 2; l++) begin
				ge[l]          = lane_in[l].rem >= dsh;
				lane_nx[l]     = lane_in[l];
				lane_nx[l].rem = ge[l] ? lane_in[l].rem - dsh : lane_in[l].rem;
				lane_nx[l].quo = lane_in[l].quo | (QW'(ge[l]) << BIT);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sd[j] <= 1'b0;
			end else if (en_sd[j]) begin
				vld_sd[j] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en_sd[j]) begin
				side_sd[j] <= side_in;
				lane_sd[j] <= lane_nx;
			end
		end
	end

	// last stage: add the base, saturate, clear parallel results
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			qext_c[l] = $signed({2'b00, lane_sd[NDIV-1][l].quo});
			sum_c[l]  = SW'(lane_sd[NDIV-1][l].base)
				+ (lane_sd[NDIV-1][l].neg ? -qext_c[l] : qext_c[l]);
			if (lane_sd[NDIV-1][l].ovf) begin
				cross_c[l] = lane_sd[NDIV-1][l].neg ? COORD_MIN : COORD_MAX;
			end else if (sum_c[l] > SUM_MAX) begin
				cross_c[l] = COORD_MAX;
			end else if (sum_c[l] < SUM_MIN) begin
				cross_c[l] = COORD_MIN;
			end else begin
				cross_c[l] = sum_c[l][W-1:0];
			end
		end
		res_c.hit      = side_sd[NDIV-1].hit && !side_sd[NDIV-1].par;
		res_c.parallel = side_sd[NDIV-1].par;
		res_c.cross_x  = side_sd[NDIV-1].par ? '0 : cross_c[0];
		res_c.cross_y  = side_sd[NDIV-1].par ? '0 : cross_c[1];
	end

	always_ff @(posedge clk) begin
		if (en_sl) begin
			res_sl <= res_c;
		end
	end

	assign isect_valid = vld_sl;
	assign isect       = res_sl;

	// checks
	`SEGINT_ASSERT_SAME(a_parallel_clean, clk, arst_n, isect_valid && isect.parallel, !isect.hit && isect.cross_x == '0 && isect.cross_y == '0)
	`SEGINT_ASSERT_SAME(a_empty_out_ready, clk, arst_n, !isect_valid, seg_ready)
	`SEGINT_ASSERT_NEXT(a_transfer_lands, clk, arst_n, seg_valid && seg_ready, vld_s1)
	`SEGINT_ASSERT_NEXT(a_stall_keeps, clk, arst_n, vld_s8 && !en_s8, vld_s8)

endmodule

`default_nettype wire

FILE: tb/tb_segment_intersection.sv
// ----------------------------------------------------------------------------
// tb_segment_intersection
// Self-checking bench for the segment intersection pipeline. Segment pairs
// are pushed through the input channel in random bursts while the result
// channel stalls on its own pattern. A scoreboard predicts hit, parallel and
// the saturated crossing point from exact integer cross products and checks
// every result transfer in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_segment_intersection;

	localparam int RANDOM_PAIRS  = 950;
	localparam int HOLD_CYCLES   = 200;
	localparam int HOLD_PAIRS    = 80;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT   = 200000;

	// scoreboard: predicts each accepted pair and checks results in order
	class isect_scoreboard;
		segint_pkg::isect_t    expected_isects[$];
		segint_pkg::seg_pair_t pending_pairs[$];
		int                    mismatches;

		// exact crossing coordinate, truncated toward zero and saturated
		function segint_pkg::coord_t crossing_coord(longint base, longint dir, longint tn,
				longint den);
			longint lo;
			longint hi;
			longint v;
			lo = -(longint'(1) <<< (segint_pkg::COORD_WIDTH - 1));
			hi = -lo - 1;
			v = base + (dir * tn) / den;
			if (v < lo)
				v = lo;
			else if (v > hi)
				v = hi;
			return segint_pkg::coord_t'(v);
		endfunction

		function segint_pkg::isect_t predict_isect(segint_pkg::seg_pair_t p);
			longint px, py, rx, ry, qx, qy, sx, sy, dx, dy;
			longint den, tn, un;
			segint_pkg::isect_t r;
			px = longint'($signed(p.seg1_start_x));
			py = longint'($signed(p.seg1_start_y));
			rx = longint'($signed(p.seg1_end_x)) - px;
			ry = longint'($signed(p.seg1_end_y)) - py;
			qx = longint'($signed(p.seg2_start_x));
			qy = longint'($signed(p.seg2_start_y));
			sx = longint'($signed(p.seg2_end_x)) - qx;
			sy = longint'($signed(p.seg2_end_y)) - qy;
			dx = qx - px;
			dy = qy - py;
			den = rx * sy - ry * sx;
			tn = dx * sy - dy * sx;
			un = dx * ry - dy * rx;
			r = '0;
			// zero denominator: parallel flag, no hit, point at origin
			if (den == 0) begin
				r.parallel = 1'b1;
				return r;
			end
			if (den < 0) begin
				den = -den;
				tn = -tn;
				un = -un;
			end
			r.hit = (tn >= 0) && (tn <= den) && (un >= 0) && (un <= den);
			r.cross_x = crossing_coord(px, rx, tn, den);
			r.cross_y = crossing_coord(py, ry, tn, den);
			return r;
		endfunction

		function void note_pair(segint_pkg::seg_pair_t p);
			expected_isects.push_back(predict_isect(p));
			pending_pairs.push_back(p);
		endfunction

		function void check_isect(segint_pkg::isect_t got);
			segint_pkg::isect_t    want;
			segint_pkg::seg_pair_t p;
			if (expected_isects.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: hit=%0b par=%0b x=%h y=%h",
						got.hit, got.parallel, got.cross_x, got.cross_y);
				return;
			end
			want = expected_isects.pop_front();
			p = pending_pairs.pop_front();
			if (got.hit !== want.hit || got.parallel !== want.parallel ||
					got.cross_x !== want.cross_x || got.cross_y !== want.cross_y) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch for pair %h", p);
					$display("  expected hit=%0b par=%0b x=%h y=%h",
						want.hit, want.parallel, want.cross_x, want.cross_y);
					$display("  actual   hit=%0b par=%0b x=%h y=%h",
						got.hit, got.parallel, got.cross_x, got.cross_y);
				end
			end
		endfunction

		function int pending();
			return expected_isects.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  seg_valid;
	logic                  seg_ready;
	segint_pkg::seg_pair_t seg;
	logic                  isect_valid;
	logic                  isect_ready;
	segint_pkg::isect_t    isect;

	isect_scoreboard sb;
	int  burst_left;
	int  cycle_count;
	bit  hold_req;

	segment_intersection DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.seg_valid   (seg_valid),
		.seg_ready   (seg_ready),
		.seg         (seg),
		.isect_valid (isect_valid),
		.isect_ready (isect_ready),
		.isect       (isect)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// transfer monitor: inputs noted before outputs are checked
	always @(posedge clk) begin
		if (arst_n) begin
			if (seg_valid && seg_ready)
				sb.note_pair(seg);
			if (isect_valid && isect_ready)
				sb.check_isect(isect);
		end
	end

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("status: fail");
		$finish;
	end

	// result side stall pattern, with a long hold-off on request
	initial begin : receiver
		int run_len;
		int mode;
		int tick;
		run_len = 0;
		mode = 0;
		tick = 0;
		isect_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				isect_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				if (run_len == 0) begin
					mode = $urandom_range(0, 3);
					run_len = $urandom_range(5, 60);
				end
				run_len--;
				tick++;
				case (mode)
					0: isect_ready <= 1'b1;
					1: isect_ready <= 1'($urandom_range(0, 1));
					2: isect_ready <= ($urandom_range(0, 3) == 0);
					default: isect_ready <= tick[0];
				endcase
				@(posedge clk);
			end
		end
	end

	function automatic segint_pkg::seg_pair_t make_pair(int ax, int ay, int bx, int by,
			int cx, int cy, int ex, int ey);
		segint_pkg::seg_pair_t p;
		p.seg1_start_x = segint_pkg::coord_t'(ax);
		p.seg1_start_y = segint_pkg::coord_t'(ay);
		p.seg1_end_x   = segint_pkg::coord_t'(bx);
		p.seg1_end_y   = segint_pkg::coord_t'(by);
		p.seg2_start_x = segint_pkg::coord_t'(cx);
		p.seg2_start_y = segint_pkg::coord_t'(cy);
		p.seg2_end_x   = segint_pkg::coord_t'(ex);
		p.seg2_end_y   = segint_pkg::coord_t'(ey);
		return p;
	endfunction

	function automatic int small_coord();
		return $urandom_range(0, 4095) - 2048;
	endfunction

	// random pair, mostly shaped to reach hits, parallels and saturation
	function automatic segint_pkg::seg_pair_t random_pair();
		int kind;
		int x0, y0, rx, ry, k, j, cx, cy;
		kind = $urandom_range(0, 99);
		if (kind < 30) begin
			return make_pair($urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom);
		end else if (kind < 65) begin
			return make_pair(small_coord(), small_coord(), small_coord(), small_coord(),
				small_coord(), small_coord(), small_coord(), small_coord());
		end else if (kind < 80) begin
			// parallel, possibly collinear
			x0 = $urandom_range(0, 16383) - 8192;
			y0 = $urandom_range(0, 16383) - 8192;
			rx = small_coord();
			ry = small_coord();
			k = $urandom_range(0, 3) - 2;
			if (k >= 0)
				k++;
			if ($urandom_range(0, 1)) begin
				j = $urandom_range(0, 3) - 1;
				cx = x0 + rx * j;
				cy = y0 + ry * j;
			end else begin
				cx = x0 + small_coord();
				cy = y0 + small_coord();
			end
			return make_pair(x0, y0, x0 + rx, y0 + ry, cx, cy, cx + k * rx, cy + k * ry);
		end else if (kind < 90) begin
			// shared endpoint
			x0 = small_coord();
			y0 = small_coord();
			rx = small_coord();
			ry = small_coord();
			if ($urandom_range(0, 1))
				return make_pair(x0, y0, rx, ry, rx, ry, small_coord(), small_coord());
			else
				return make_pair(x0, y0, rx, ry, small_coord(), small_coord(), x0, y0);
		end else begin
			// nearly parallel, crossing far off
			rx = $urandom_range(256, 8192);
			ry = rx + $urandom_range(0, 4) - 2;
			x0 = small_coord();
			y0 = small_coord();
			cx = small_coord();
			cy = small_coord();
			if ($urandom_range(0, 1))
				return make_pair(x0, y0, x0 + rx, y0 + ry, cx, cy, cx + rx, cy + ry + 1);
			else
				return make_pair(x0, y0, x0 - rx, y0 - ry, cx, cy, cx - rx, cy - ry + 1);
		end
	endfunction

	// hold the pair on the input until it transfers
	task automatic send_pair(input segint_pkg::seg_pair_t p);
		seg <= p;
		seg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!seg_ready);
	endtask

	// bursts of transfers separated by random idle gaps
	task automatic offer_pair(input segint_pkg::seg_pair_t p);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				seg_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		send_pair(p);
		burst_left--;
	endtask

	task automatic drain_results();
		seg_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic run_directed();
		// all zero, all minimum, all maximum: degenerate
		offer_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
		offer_pair(make_pair(-32768, -32768, -32768, -32768,
			-32768, -32768, -32768, -32768));
		offer_pair(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
		// plain crossing at (1,1), both orientations
		offer_pair(make_pair(0, 0, 512, 512, 0, 512, 512, 0));
		offer_pair(make_pair(0, 0, 512, 512, 512, 0, 0, 512));
		// carrying lines cross outside the segments
		offer_pair(make_pair(0, 0, 256, 256, 1024, 0, 768, 256));
		// parallel distinct, collinear overlapping
		offer_pair(make_pair(0, 0, 256, 0, 0, 256, 256, 256));
		offer_pair(make_pair(0, 0, 512, 0, 256, 0, 768, 0));
		// touching at t=1, u=0 and at t=0
		offer_pair(make_pair(0, 0, 256, 256, 256, 256, 512, 0));
		offer_pair(make_pair(0, 0, 256, 256, -256, 256, 256, -256));
		// one segment is a point
		offer_pair(make_pair(100, 100, 100, 100, 0, 0, 256, 256));
		// crossing beyond the coordinate range, high and low
		offer_pair(make_pair(0, 0, 256, 1, 0, 256, 256, 256));
		offer_pair(make_pair(0, 0, -256, -1, 0, -256, -256, -256));
		// full-range diagonals and axes
		offer_pair(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
		offer_pair(make_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
		offer_pair(make_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
		// truncation of negative quotients
		offer_pair(make_pair(0, 0, -768, -256, -100, 0, -100, -300));
		offer_pair(make_pair(5, 7, -761, 263, -333, -31, 101, 17));
		// alternating bit patterns
		offer_pair(make_pair(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555,
			16'hAAAA, 16'hAAAA, 16'h5555, 16'h5555));
		// just past t=1
		offer_pair(make_pair(0, 0, 256, 0, 257, -256, 257, 256));
	endtask

	// stimulus
	initial begin
		sb = new;
		hold_req = 1'b0;
		burst_left = 0;
		arst_n <= 1'b0;
		seg_valid <= 1'b0;
		seg <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		// sender pauses until every result is back
		drain_results();

		for (int i = 0; i < RANDOM_PAIRS / 2; i++)
			offer_pair(random_pair());

		// long receiver hold-off while the input keeps offering
		hold_req = 1'b1;
		burst_left = HOLD_PAIRS;
		for (int i = 0; i < HOLD_PAIRS; i++)
			offer_pair(random_pair());

		for (int i = 0; i < RANDOM_PAIRS / 2 - HOLD_PAIRS; i++)
			offer_pair(random_pair());

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/segint_pkg.sv
rtl/segment_intersection.sv
tb/tb_segment_intersection.sv
